### hw/rtl/i2crt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i2crt_pkg;
    localparam int MAX_BYTES_DEF = 16;
    localparam int IN_W  = 24;
    localparam int OUT_W = 16;
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;
    localparam logic [1:0] REG_DEV  = 2'd0;
    localparam logic [1:0] REG_HALF = 2'd1;
    localparam logic [1:0] REG_TMO  = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic       sda_in;
        logic [7:0] reg_addr;
        logic [7:0] byte_value;
        logic [4:0] byte_count;
    } item_t;

    typedef struct packed {
        logic       status;
        logic       done_res;
        logic       read_last;
        logic       read_valid;
        logic [7:0] read_data;
        logic       busy_res;
        logic       sda_enable;
        logic       sda_out;
        logic       scl;
    } result_t;
endpackage
`default_nettype wire

### hw/rtl/i2crt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module i2crt_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  i2crt_pkg::item_t     in_item,
    output logic                 out_valid,
    input  wire                  out_ready,
    output i2crt_pkg::item_t     out_item
);
    import i2crt_pkg::*;
    // two-entry queue, full throughput
    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### hw/rtl/i2crt_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module i2crt_engine #(
    parameter int MAX_BYTES = i2crt_pkg::MAX_BYTES_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  i2crt_pkg::item_t     in_item,
    input  wire [6:0]            device_address,
    input  wire [15:0]           half_period_ticks,
    input  wire [7:0]            ack_timeout,
    output logic                 out_valid,
    input  wire                  out_ready,
    output i2crt_pkg::result_t   out_res
);
    import i2crt_pkg::*;
    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int BW = $clog2(MAX_BYTES + 3);

    typedef enum logic [19:0] {
        PH_IDLE = 20'd1 << 0,  PH_ST_A = 20'd1 << 1,  PH_ST_B = 20'd1 << 2,
        PH_TX_L = 20'd1 << 3,  PH_TX_H = 20'd1 << 4,  PH_AK_L = 20'd1 << 5,
        PH_AK_H = 20'd1 << 6,  PH_RS_A = 20'd1 << 7,  PH_RS_B = 20'd1 << 8,
        PH_RS_C = 20'd1 << 9,  PH_RX_L = 20'd1 << 10, PH_RX_H = 20'd1 << 11,
        PH_MA_L = 20'd1 << 12, PH_MA_H = 20'd1 << 13, PH_SP_A = 20'd1 << 14,
        PH_SP_B = 20'd1 << 15, PH_SP_C = 20'd1 << 16, PH_SE_A = 20'd1 << 17,
        PH_SE_B = 20'd1 << 18, PH_SE_C = 20'd1 << 19
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [2:0]    bit_reg, bit_next;
    logic [BW-1:0] byte_reg, byte_next;
    logic [7:0]    shift_reg, shift_next;
    logic [15:0]   div_reg, div_next;
    logic [7:0]    tmo_reg, tmo_next;
    logic [CW-1:0] load_reg, load_next;
    logic          rd_reg, rd_next;
    logic [7:0]    treg_reg, treg_next;
    logic [CW-1:0] total_reg, total_next;
    logic [7:0]    wbuf [MAX_BYTES];
    logic [7:0]    wbyte;
    logic          out_v_reg;
    result_t       res_reg, res_next;
    logic          step, half_end, last_byte;
    logic [BW-1:0] d_idx;

    // output register frees as soon as it is taken
    assign in_ready  = !out_v_reg || out_ready;
    assign out_valid = out_v_reg;
    assign out_res   = res_reg;
    assign step      = in_valid && in_ready;
    assign half_end  = !({1'b0, div_reg} + 17'd1 < {1'b0, half_period_ticks});
    // buffer entry of the next data byte
    assign d_idx     = byte_reg - BW'(1);
    assign wbyte     = wbuf[d_idx[AW-1:0]];
    assign last_byte = ({1'b0, byte_reg} + (BW+1)'(1)) >= (BW+1)'(total_reg);

    always_ff @(posedge clk)
    begin
        if (step && phase_reg == PH_IDLE && in_item.command == CMD_LOAD
            && load_reg < CW'(MAX_BYTES))
        begin
            wbuf[load_reg[AW-1:0]] <= in_item.byte_value;
        end
    end

    always_comb
    begin
        phase_next = phase_reg; bit_next = bit_reg; byte_next = byte_reg;
        shift_next = shift_reg; div_next = div_reg; tmo_next = tmo_reg;
        load_next = load_reg; rd_next = rd_reg; treg_next = treg_reg;
        total_next = total_reg;
        res_next = '0;
        if (phase_reg == PH_IDLE)
        begin
            if (in_item.command == CMD_LOAD)
            begin
                if (load_reg < CW'(MAX_BYTES)) load_next = load_reg + CW'(1);
            end
            else if (in_item.command == CMD_WRITE || in_item.command == CMD_READ)
            begin
                rd_next = (in_item.command == CMD_READ);
                treg_next = in_item.reg_addr;
                total_next = ({27'd0, in_item.byte_count} > MAX_BYTES) ?
                             CW'(MAX_BYTES) : CW'(in_item.byte_count);
                if (!rd_next) load_next = '0;
                shift_next = {device_address, 1'b0};
                bit_next = '0; byte_next = '0; div_next = '0; tmo_next = '0;
                phase_next = PH_ST_A;
            end
        end
        else if (!half_end)
        begin
            div_next = div_reg + 16'd1;
        end
        else
        begin
            div_next = '0;
            case (phase_reg)
                PH_ST_A: phase_next = PH_ST_B;
                PH_ST_B: phase_next = PH_TX_L;
                PH_TX_L: phase_next = PH_TX_H;
                PH_TX_H:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next = bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        tmo_next = '0;
                        phase_next = PH_AK_L;
                    end
                    else phase_next = PH_TX_L;
                end
                PH_AK_L: phase_next = PH_AK_H;
                PH_AK_H:
                begin
                    if (!in_item.sda_in)
                    begin
                        bit_next = '0;
                        if (!rd_reg)
                        begin
                            if ({1'b0, byte_reg} < (BW+1)'(total_reg) + (BW+1)'(1))
                            begin
                                byte_next = byte_reg + BW'(1);
                                phase_next = PH_TX_L;
                                shift_next = (byte_reg == BW'(0)) ? treg_reg : wbyte;
                            end
                            else phase_next = PH_SP_A;
                        end
                        else if (byte_reg == BW'(0))
                        begin
                            byte_next = BW'(1);
                            shift_next = treg_reg;
                            phase_next = PH_TX_L;
                        end
                        else if (byte_reg == BW'(1))
                        begin
                            byte_next = BW'(2);
                            phase_next = PH_RS_A;
                        end
                        else if (total_reg == '0) phase_next = PH_SP_A;
                        else
                        begin
                            byte_next = '0;
                            shift_next = '0;
                            phase_next = PH_RX_L;
                        end
                    end
                    else
                    begin
                        tmo_next = tmo_reg + 8'd1;
                        if (tmo_next >= ack_timeout) phase_next = PH_SE_A;
                    end
                end
                PH_RS_A: phase_next = PH_RS_B;
                PH_RS_B: phase_next = PH_RS_C;
                PH_RS_C:
                begin
                    shift_next = {device_address, 1'b1};
                    bit_next = '0;
                    phase_next = PH_TX_L;
                end
                PH_RX_L: phase_next = PH_RX_H;
                PH_RX_H:
                begin
                    shift_next = {shift_reg[6:0], in_item.sda_in};
                    bit_next = bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        res_next.read_data = shift_next;
                        res_next.read_valid = 1'b1;
                        res_next.read_last = last_byte;
                        phase_next = PH_MA_L;
                    end
                    else phase_next = PH_RX_L;
                end
                PH_MA_L: phase_next = PH_MA_H;
                PH_MA_H:
                begin
                    if (last_byte) phase_next = PH_SP_A;
                    else
                    begin
                        byte_next = byte_reg + BW'(1);
                        shift_next = '0;
                        phase_next = PH_RX_L;
                    end
                end
                PH_SP_A: phase_next = PH_SP_B;
                PH_SP_B: phase_next = PH_SP_C;
                PH_SP_C:
                begin
                    phase_next = PH_IDLE;
                    res_next.done_res = 1'b1;
                end
                PH_SE_A: phase_next = PH_SE_B;
                PH_SE_B: phase_next = PH_SE_C;
                PH_SE_C:
                begin
                    phase_next = PH_IDLE;
                    res_next.done_res = 1'b1;
                    res_next.status = 1'b1;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
        res_next.scl = 1'b1;
        res_next.sda_out = 1'b1;
        res_next.sda_enable = 1'b1;
        res_next.busy_res = (phase_next != PH_IDLE);
        case (phase_next)
            PH_ST_A: ;
            PH_ST_B: res_next.sda_out = 1'b0;
            PH_TX_L:
            begin
                res_next.scl = 1'b0;
                res_next.sda_out = shift_next[7];
            end
            PH_TX_H: res_next.sda_out = shift_next[7];
            PH_AK_L, PH_RX_L:
            begin
                res_next.scl = 1'b0;
                res_next.sda_enable = 1'b0;
            end
            PH_AK_H, PH_RX_H: res_next.sda_enable = 1'b0;
            PH_RS_A: res_next.scl = 1'b0;
            PH_RS_B: ;
            PH_RS_C: res_next.sda_out = 1'b0;
            PH_MA_L, PH_MA_H:
            begin
                res_next.scl = (phase_next == PH_MA_H);
                res_next.sda_out = ({1'b0, byte_next} + (BW+1)'(1))
                                   >= (BW+1)'(total_next);
            end
            PH_SP_A, PH_SE_A:
            begin
                res_next.scl = 1'b0;
                res_next.sda_out = 1'b0;
            end
            PH_SP_B, PH_SE_B: res_next.sda_out = 1'b0;
            PH_SP_C, PH_SE_C: ;
            default: res_next.sda_enable = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (step) res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; bit_reg <= '0; byte_reg <= '0;
            shift_reg <= '0; div_reg <= '0; tmo_reg <= '0; load_reg <= '0;
            rd_reg <= 1'b0; treg_reg <= '0; total_reg <= '0; out_v_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next; bit_reg <= bit_next;
                byte_reg <= byte_next; shift_reg <= shift_next;
                div_reg <= div_next; tmo_reg <= tmo_next; load_reg <= load_next;
                rd_reg <= rd_next; treg_reg <= treg_next; total_reg <= total_next;
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/i2c_register_transaction_master.sv
`timescale 1ns / 1ps
// i2c register transaction master
// s_axis carries one item per bus tick: a plain tick, a write-buffer load,
// or the start of a register write or read; sda_in is the line sampled then.
// m_axis returns one item per input item: scl, sda_out, sda_enable, busy,
// and any read byte, done and status raised on that tick.
// cfg_we/cfg_index/cfg_data set address, half period and ack timeout;
// write them only while no transaction runs.
// an item passes a two-entry queue, then the sequencer steps once and its
// result lands in an output register; one item per cycle is sustained
// while m_axis_tready stays high.
// reset puts the bus idle (scl high, sda released), empties the queue and
// the write buffer count; buffer contents are not cleared.
// a stalled m_axis_tready holds the result and backs up into the queue, then
// s_axis_tready drops; no item is lost or repeated.
`default_nettype none
module i2c_register_transaction_master #(
    parameter int MAX_BYTES = i2crt_pkg::MAX_BYTES_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // command[1:0], sda_in[2], reg_addr[10:3], byte_value[18:11], byte_count[23:19]
    input  wire [i2crt_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // scl, sda_out, sda_enable, busy_res, read_data[11:4], read_valid,
    // read_last, done_res, status[15]
    output logic [i2crt_pkg::OUT_W-1:0] m_axis_tdata,
    input  wire                         cfg_we,
    input  wire [1:0]                   cfg_index,
    input  wire [15:0]                  cfg_data
);
    import i2crt_pkg::*;
    item_t   in_item, q_item;
    result_t res;
    logic    q_valid, q_ready;
    logic [6:0]  dev_reg;
    logic [15:0] half_reg;
    logic [7:0]  tmo_reg;

    assign in_item.command    = s_axis_tdata[1:0];
    assign in_item.sda_in     = s_axis_tdata[2];
    assign in_item.reg_addr   = s_axis_tdata[10:3];
    assign in_item.byte_value = s_axis_tdata[18:11];
    assign in_item.byte_count = s_axis_tdata[23:19];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg <= 7'd80;
            half_reg <= 16'd5;
            tmo_reg <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEV:  dev_reg <= cfg_data[6:0];
                REG_HALF: half_reg <= cfg_data;
                REG_TMO:  tmo_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    i2crt_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    i2crt_engine #(.MAX_BYTES(MAX_BYTES)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .device_address(dev_reg), .half_period_ticks(half_reg),
        .ack_timeout(tmo_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    assign m_axis_tdata = {res.status, res.done_res, res.read_last, res.read_valid,
                           res.read_data, res.busy_res, res.sda_enable,
                           res.sda_out, res.scl};
endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import i2crt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BUF_DEPTH = 16;

    localparam int PH_IDLE = 0, PH_ST_A = 1, PH_ST_B = 2, PH_TX_L = 3, PH_TX_H = 4;
    localparam int PH_AK_L = 5, PH_AK_H = 6, PH_RS_A = 7, PH_RS_B = 8, PH_RS_C = 9;
    localparam int PH_RX_L = 10, PH_RX_H = 11, PH_MA_L = 12, PH_MA_H = 13;
    localparam int PH_SP_A = 14, PH_SP_B = 15, PH_SP_C = 16;
    localparam int PH_SE_A = 17, PH_SE_B = 18, PH_SE_C = 19;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    i2c_register_transaction_master uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // bus model state
    int dev_addr, half_ticks, ack_limit;
    int bus_phase, bit_ix, byte_ix, shreg, div_cnt, tmo_cnt;
    int load_cnt, rd_mode, tgt_reg, n_bytes;
    int wbuf [BUF_DEPTH];
    int buf_filled;

    result_t line_q[$];
    int mismatches;
    int sent_items;
    int cycles;
    int tx_idle_pct, rx_idle_pct;
    int rx_hold;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver readiness, with an optional long hold-off
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic void load_byte(int v);
        shreg = v & 8'hFF;
        bit_ix = 0;
        bus_phase = PH_TX_L;
    endfunction

    function automatic void after_ack();
        if (!rd_mode)
        begin
            if (byte_ix + 1 < n_bytes + 2)
            begin
                byte_ix++;
                if (byte_ix == 1)
                    load_byte(tgt_reg);
                else
                    load_byte(wbuf[byte_ix - 2]);
            end
            else
                bus_phase = PH_SP_A;
        end
        else if (byte_ix == 0)
        begin
            byte_ix = 1;
            load_byte(tgt_reg);
        end
        else if (byte_ix == 1)
        begin
            byte_ix = 2;
            bus_phase = PH_RS_A;
        end
        else if (n_bytes == 0)
            bus_phase = PH_SP_A;
        else
        begin
            byte_ix = 0;
            bit_ix = 0;
            shreg = 0;
            bus_phase = PH_RX_L;
        end
    endfunction

    // advance the bus one tick and return the line levels after it
    function automatic result_t bus_tick(logic [1:0] cmd, bit sda, int rg, int bv, int cnt);
        result_t r;
        r = '0;
        r.scl = 1'b1;
        r.sda_out = 1'b1;
        if (bus_phase == PH_IDLE)
        begin
            if (cmd == CMD_LOAD)
            begin
                if (load_cnt < BUF_DEPTH)
                begin
                    wbuf[load_cnt] = bv;
                    load_cnt++;
                    if (load_cnt > buf_filled)
                        buf_filled = load_cnt;
                end
            end
            else if (cmd == CMD_WRITE || cmd == CMD_READ)
            begin
                rd_mode = (cmd == CMD_READ);
                tgt_reg = rg;
                n_bytes = (cnt > BUF_DEPTH) ? BUF_DEPTH : cnt;
                if (!rd_mode)
                    load_cnt = 0;
                shreg = (dev_addr << 1) & 8'hFE;
                bit_ix = 0;
                byte_ix = 0;
                div_cnt = 0;
                tmo_cnt = 0;
                bus_phase = PH_ST_A;
            end
        end
        else if (div_cnt + 1 < half_ticks)
            div_cnt++;
        else
        begin
            div_cnt = 0;
            case (bus_phase)
                PH_ST_A: bus_phase = PH_ST_B;
                PH_ST_B: bus_phase = PH_TX_L;
                PH_TX_L: bus_phase = PH_TX_H;
                PH_TX_H:
                begin
                    shreg = (shreg << 1) & 8'hFF;
                    if (bit_ix >= 7)
                    begin
                        bit_ix = 0;
                        tmo_cnt = 0;
                        bus_phase = PH_AK_L;
                    end
                    else
                    begin
                        bit_ix++;
                        bus_phase = PH_TX_L;
                    end
                end
                PH_AK_L: bus_phase = PH_AK_H;
                PH_AK_H:
                begin
                    if (!sda)
                        after_ack();
                    else
                    begin
                        tmo_cnt = (tmo_cnt + 1) & 8'hFF;
                        if (tmo_cnt >= ack_limit)
                            bus_phase = PH_SE_A;
                    end
                end
                PH_RS_A: bus_phase = PH_RS_B;
                PH_RS_B: bus_phase = PH_RS_C;
                PH_RS_C: load_byte((dev_addr << 1) | 1);
                PH_RX_L: bus_phase = PH_RX_H;
                PH_RX_H:
                begin
                    shreg = ((shreg << 1) | sda) & 8'hFF;
                    if (bit_ix >= 7)
                    begin
                        bit_ix = 0;
                        r.read_data = shreg[7:0];
                        r.read_valid = 1'b1;
                        r.read_last = (byte_ix + 1 >= n_bytes);
                        bus_phase = PH_MA_L;
                    end
                    else
                    begin
                        bit_ix++;
                        bus_phase = PH_RX_L;
                    end
                end
                PH_MA_L: bus_phase = PH_MA_H;
                PH_MA_H:
                begin
                    if (byte_ix + 1 >= n_bytes)
                        bus_phase = PH_SP_A;
                    else
                    begin
                        byte_ix++;
                        shreg = 0;
                        bus_phase = PH_RX_L;
                    end
                end
                PH_SP_A: bus_phase = PH_SP_B;
                PH_SP_B: bus_phase = PH_SP_C;
                PH_SP_C:
                begin
                    bus_phase = PH_IDLE;
                    r.done_res = 1'b1;
                end
                PH_SE_A: bus_phase = PH_SE_B;
                PH_SE_B: bus_phase = PH_SE_C;
                PH_SE_C:
                begin
                    bus_phase = PH_IDLE;
                    r.done_res = 1'b1;
                    r.status = 1'b1;
                end
                default: bus_phase = PH_IDLE;
            endcase
        end

        case (bus_phase)
            PH_ST_A: {r.scl, r.sda_out, r.sda_enable} = 3'b111;
            PH_ST_B: {r.scl, r.sda_out, r.sda_enable} = 3'b101;
            PH_TX_L: {r.scl, r.sda_out, r.sda_enable} = {1'b0, shreg[7], 1'b1};
            PH_TX_H: {r.scl, r.sda_out, r.sda_enable} = {1'b1, shreg[7], 1'b1};
            PH_AK_L, PH_RX_L: r.scl = 1'b0;
            PH_RS_A: {r.scl, r.sda_out, r.sda_enable} = 3'b011;
            PH_RS_B: {r.scl, r.sda_out, r.sda_enable} = 3'b111;
            PH_RS_C: {r.scl, r.sda_out, r.sda_enable} = 3'b101;
            PH_MA_L, PH_MA_H:
            begin
                r.scl = (bus_phase == PH_MA_H);
                r.sda_out = (byte_ix + 1 >= n_bytes);
                r.sda_enable = 1'b1;
            end
            PH_SP_A, PH_SE_A: {r.scl, r.sda_out, r.sda_enable} = 3'b001;
            PH_SP_B, PH_SE_B: {r.scl, r.sda_out, r.sda_enable} = 3'b101;
            PH_SP_C, PH_SE_C: {r.scl, r.sda_out, r.sda_enable} = 3'b111;
            default: ;
        endcase
        r.busy_res = (bus_phase != PH_IDLE);
        return r;
    endfunction

    // one item through the slave side; called at a falling edge, returns at one
    task automatic send_item(logic [1:0] cmd, bit sda, int rg, int bv, int cnt);
        // never start a write that would reach unloaded buffer entries
        if (cmd == CMD_WRITE && bus_phase == PH_IDLE &&
            ((cnt > BUF_DEPTH) ? BUF_DEPTH : cnt) > buf_filled)
            cnt = buf_filled;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {cnt[4:0], bv[7:0], rg[7:0], sda, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        line_q.push_back(bus_tick(cmd, sda, rg, bv, cnt));
        sent_items++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic bus_tick_item(int nack_pct);
        send_item(2'($urandom_range(3)), ($urandom_range(99) < nack_pct),
                  $urandom_range(255), $urandom_range(255), $urandom_range(31));
    endtask

    // start a transaction and tick until it ends; stray commands ride along
    task automatic run_txn(logic [1:0] cmd, int rg, int cnt, int nack_pct);
        send_item(cmd, 1'b0, rg, $urandom_range(255), cnt);
        while (bus_phase != PH_IDLE)
            bus_tick_item(nack_pct);
    endtask

    task automatic load_bytes(int n);
        for (int i = 0; i < n; i++)
            send_item(CMD_LOAD, $urandom_range(1), $urandom_range(255),
                      $urandom_range(255), $urandom_range(31));
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        while (line_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val[15:0];
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_DEV)
            dev_addr = val & 8'h7F;
        else if (idx == REG_HALF)
            half_ticks = val & 16'hFFFF;
        else if (idx == REG_TMO)
            ack_limit = val & 8'hFF;
    endtask

    function automatic void check_bit(string name, int expv, int got);
        if (expv != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h got %0h at %0t", name, expv, got, $realtime);
        end
    endfunction

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata);
            if (line_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item %h at %0t", m_axis_tdata, $realtime);
            end
            else
            begin
                want = line_q.pop_front();
                check_bit("scl", want.scl, got.scl);
                check_bit("sda_out", want.sda_out, got.sda_out);
                check_bit("sda_enable", want.sda_enable, got.sda_enable);
                check_bit("busy", want.busy_res, got.busy_res);
                check_bit("read_data", want.read_data, got.read_data);
                check_bit("read_valid", want.read_valid, got.read_valid);
                check_bit("read_last", want.read_last, got.read_last);
                check_bit("done", want.done_res, got.done_res);
                check_bit("status", want.status, got.status);
            end
        end
    end

    // default settings: zero-byte write, extreme data values stay in the buffer
    task automatic test_reset_defaults();
        send_item(CMD_LOAD, 1'b0, 0, 8'h00, 0);
        send_item(CMD_LOAD, 1'b1, 255, 8'hFF, 31);
        run_txn(CMD_WRITE, 8'hA5, 0, 0);
    endtask

    // address and timeout extremes, single-byte and zero-byte reads,
    // then a write of the extreme bytes left in the buffer
    task automatic test_config_extremes();
        write_reg(REG_HALF, 1);
        write_reg(REG_DEV, 127);
        write_reg(REG_TMO, 1);
        run_txn(CMD_READ, 8'hFF, 1, 0);
        write_reg(REG_DEV, 0);
        run_txn(CMD_READ, 8'h00, 0, 0);
        run_txn(CMD_WRITE, 8'h5A, 2, 0);
    endtask

    // target never acknowledges: shortest and a long timeout
    task automatic test_ack_timeout();
        run_txn(CMD_WRITE, 8'h12, 0, 100);
        write_reg(REG_TMO, 40);
        run_txn(CMD_READ, 8'h34, 3, 100);
        write_reg(REG_TMO, 3);
    endtask

    // overfull buffer and oversized count saturate at the buffer depth
    task automatic test_buffer_limits();
        load_bytes(BUF_DEPTH + 1);
        run_txn(CMD_WRITE, 8'h80, 31, 0);
    endtask

    // slowest half period only while idle, then back to fast
    task automatic test_slow_clock();
        write_reg(REG_HALF, 65535);
        load_bytes(2);
        write_reg(REG_HALF, 1);
        run_txn(CMD_READ, 8'h7F, 2, 20);
    endtask

    task automatic test_random_traffic(int stop_at, bit squeeze);
        int pick;
        int k;
        if (squeeze)
            rx_hold = 300;
        while (sent_items < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                write_reg(REG_DEV, $urandom_range(127));
                write_reg(REG_HALF, $urandom_range(1, 2));
                write_reg(REG_TMO, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                           : $urandom_range(1, 4));
            end
            else if (pick < 45)
            begin
                k = $urandom_range(BUF_DEPTH);
                load_bytes(k);
                run_txn(CMD_WRITE, $urandom_range(255), $urandom_range(k), 5);
            end
            else if (pick < 75)
                run_txn(CMD_READ, $urandom_range(255), $urandom_range(0, 17), 50);
            else if (pick < 85)
                run_txn(2'($urandom_range(2, 3)), $urandom_range(255),
                        $urandom_range(31), 60);
            else
                repeat ($urandom_range(1, 6)) bus_tick_item(50);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DEV;
        cfg_data = '0;
        mismatches = 0;
        sent_items = 0;
        cycles = 0;
        rx_hold = 0;
        tx_idle_pct = 15;
        rx_idle_pct = 77;
        dev_addr = 80;
        half_ticks = 5;
        ack_limit = 10;
        bus_phase = PH_IDLE;
        bit_ix = 0;
        byte_ix = 0;
        shreg = 0;
        div_cnt = 0;
        tmo_cnt = 0;
        load_cnt = 0;
        rd_mode = 0;
        tgt_reg = 0;
        n_bytes = 0;
        buf_filled = 0;
        foreach (wbuf[i])
            wbuf[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_config_extremes();
        test_ack_timeout();
        test_buffer_limits();
        test_slow_clock();
        test_random_traffic(sent_items + 50, 1'b1);
        tx_idle_pct = 77;
        rx_idle_pct = 15;
        test_random_traffic(sent_items + 50, 1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(sent_items + 50, 1'b0);

        while (line_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
